@@ design/lapsh_pkg.sv @@
package lapsh_pkg;

    // field and register widths
    localparam int PIX_W      = 8;
    localparam int SIZE_W     = 11;
    localparam int GAIN_W     = 12;
    localparam int ROW_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHARPEN_GAIN = 2'd2;

    // input beat kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // register reset values and limits
    localparam logic [SIZE_W-1:0] SIZE_RESET   = 11'd1024;
    localparam logic [SIZE_W-1:0] HEIGHT_LIMIT = 11'd1024;
    localparam logic [GAIN_W-1:0] GAIN_RESET   = 12'hF00;
    localparam logic [PIX_W-1:0]  PIX_MAX      = 8'd255;

    // output queue
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 2;

    // per-beat control carried from the address stage to the compute stage
    typedef struct packed {
        logic produce;
        logic col_first;
        logic use_right;
        logic down_is_px;
        logic frame_end;
        logic upper_we;
        logic upper_from_px;
        logic fwd_upper;
    } lapsh_ctrl_t;

endpackage

@@ design/laplacian_sharpen_3x3_top.sv @@
// a result is offered on m_ once its input beat has passed the compute stage registers and the output queue
// throughput: one beat per cycle while s_ready is high; each beat makes one read pass over both line memories
// (upper at one address, middle at two) and each pixel beat makes one write to each
// reset: config registers, counters, window and output queue return to reset values;
// the line memories are not cleared and need no clearing pass
module laplacian_sharpen_3x3_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [lapsh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lapsh_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [lapsh_pkg::PIX_W-1:0]         s_pixel_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lapsh_pkg::PIX_W-1:0]         m_pixel_out,
    output logic                                m_frame_end
);
    import lapsh_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

    // configuration registers
    logic [SIZE_W-1:0]        frame_width_reg;
    logic [SIZE_W-1:0]        frame_height_reg;
    logic signed [GAIN_W-1:0] gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= SIZE_RESET;
            frame_height_reg <= SIZE_RESET;
            gain_reg         <= GAIN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[SIZE_W-1:0];
                REG_SHARPEN_GAIN: gain_reg         <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size
    logic [WW-1:0]     eff_w;
    logic [SIZE_W-1:0] eff_h;

    always_comb begin
        if (frame_width_reg == '0) begin
            eff_w = WW'(1);
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            eff_h = SIZE_W'(1);
        end else if (frame_height_reg > HEIGHT_LIMIT) begin
            eff_h = HEIGHT_LIMIT;
        end else begin
            eff_h = frame_height_reg;
        end
    end

    // position counters
    logic [AW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [WW-1:0]    pending_reg, pending_next;

    // compute stage registers
    logic               valid_a_reg;
    lapsh_ctrl_t        ctrl_a_reg;
    lapsh_ctrl_t        ctrl_next;
    logic [AW-1:0]      addr_a_reg;
    logic [PIX_W-1:0]   px_a_reg;
    logic [PIX_W-1:0]   rd_mid_reg;
    logic [PIX_W-1:0]   rd_right_reg;
    logic [PIX_W-1:0]   rd_up_reg;
    logic [PIX_W-1:0]   fwd_data_reg;
    logic [PIX_W-1:0]   prev_centre_reg;

    // output queue
    logic [PIX_W-1:0]      fifo_pix_reg [FIFO_DEPTH];
    logic                  fifo_end_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] fifo_count_reg;

    logic accept;
    logic push;
    logic pop;
    logic [FIFO_CNT_W:0] in_flight;

    // credit check: queue entries plus the beat in the compute stage
    assign in_flight = {1'b0, fifo_count_reg} + (FIFO_CNT_W+1)'(valid_a_reg);
    assign s_ready   = in_flight < (FIFO_CNT_W+1)'(FIFO_DEPTH);
    assign accept    = s_valid && s_ready;

    // address stage decode
    logic          is_flush;
    logic          flush_live;
    logic          restart;
    logic [AW-1:0] col_eff;
    logic [ROW_W-1:0] row_eff;
    logic          row_first;
    logic [AW-1:0] addr_right;
    logic [WW-1:0] col_plus;
    logic [PIX_W-1:0] upper_wdata;
    logic [PIX_W-1:0] mid_a;

    assign is_flush   = (s_kind == KIND_FLUSH);
    assign flush_live = is_flush && (pending_reg != '0);
    assign restart    = !is_flush && (pending_reg != '0);
    assign col_eff    = restart ? '0 : col_reg;
    assign row_eff    = restart ? '0 : row_reg;
    assign row_first  = (row_eff == '0);
    assign addr_right = (col_eff == LAST_ADDR) ? '0 : col_eff + AW'(1);
    assign col_plus   = WW'(col_eff) + WW'(1);

    always_comb begin
        ctrl_next.produce       = flush_live || (!is_flush && !row_first);
        ctrl_next.col_first     = (col_eff == '0);
        ctrl_next.use_right     = is_flush ? ((pending_reg > WW'(1)) && (col_eff != LAST_ADDR))
                                           : (col_plus < eff_w);
        ctrl_next.down_is_px    = !is_flush;
        ctrl_next.frame_end     = flush_live && (pending_reg == WW'(1));
        ctrl_next.upper_we      = !is_flush;
        ctrl_next.upper_from_px = row_first;
        ctrl_next.fwd_upper     = valid_a_reg && ctrl_a_reg.upper_we && (addr_a_reg == col_eff);
    end

    // counter update
    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        pending_next = pending_reg;
        if (is_flush) begin
            if (flush_live) begin
                pending_next = pending_reg - WW'(1);
                col_next     = (pending_reg == WW'(1)) ? '0 : col_reg + AW'(1);
            end
        end else begin
            pending_next = '0;
            if (col_plus >= eff_w) begin
                col_next = '0;
                if ((SIZE_W'(row_eff) + SIZE_W'(1)) >= eff_h) begin
                    row_next     = '0;
                    pending_next = eff_w;
                end else begin
                    row_next = row_eff + ROW_W'(1);
                end
            end else begin
                col_next = col_eff + AW'(1);
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            pending_reg <= '0;
        end else if (accept) begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            pending_reg <= pending_next;
        end
    end

    // line memories: read-first, registered reads
    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

    always_ff @(posedge aclk) begin
        rd_mid_reg   <= middle_mem[col_eff];
        rd_right_reg <= middle_mem[addr_right];
        if (accept && !is_flush) begin
            middle_mem[col_eff] <= s_pixel_in;
        end
    end

    always_ff @(posedge aclk) begin
        rd_up_reg <= upper_mem[col_eff];
        if (valid_a_reg && ctrl_a_reg.upper_we) begin
            upper_mem[addr_a_reg] <= upper_wdata;
        end
    end

    // compute stage pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            ctrl_a_reg  <= '0;
        end else begin
            valid_a_reg <= accept;
            ctrl_a_reg  <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_a_reg   <= col_eff;
        px_a_reg     <= s_pixel_in;
        fwd_data_reg <= upper_wdata;
    end

    // neighborhood selection
    logic [PIX_W-1:0] up_a, right_a, down_a, left_a;

    assign mid_a       = rd_mid_reg;
    assign upper_wdata = ctrl_a_reg.upper_from_px ? px_a_reg : mid_a;
    assign up_a        = ctrl_a_reg.fwd_upper ? fwd_data_reg : rd_up_reg;
    assign right_a     = ctrl_a_reg.use_right ? rd_right_reg : mid_a;
    assign down_a      = ctrl_a_reg.down_is_px ? px_a_reg : mid_a;
    assign left_a      = ctrl_a_reg.col_first ? mid_a : prev_centre_reg;

    // left neighbour from the centre of the last produced window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_centre_reg <= '0;
        end else if (valid_a_reg && ctrl_a_reg.produce) begin
            prev_centre_reg <= mid_a;
        end
    end

    // laplacian, gain and clamp
    logic [PIX_W+1:0]   cross_sum;
    logic signed [11:0] lap;
    logic signed [23:0] scaled;
    logic signed [24:0] total;
    logic [PIX_W-1:0]   sharp;

    assign cross_sum = (PIX_W+2)'(up_a) + (PIX_W+2)'(down_a)
                     + (PIX_W+2)'(left_a) + (PIX_W+2)'(right_a);
    assign lap       = $signed({2'b00, cross_sum}) - $signed({2'b00, mid_a, 2'b00});
    assign scaled    = gain_reg * lap;
    assign total     = 25'(scaled) + $signed({9'd0, mid_a, 8'd0});

    always_comb begin
        if (total[24]) begin
            sharp = '0;
        end else if (|total[23:16]) begin
            sharp = PIX_MAX;
        end else begin
            sharp = total[15:8];
        end
    end

    // output queue
    assign push = valid_a_reg && ctrl_a_reg.produce;
    assign pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_pix_reg[wr_ptr_reg] <= sharp;
            fifo_end_reg[wr_ptr_reg] <= ctrl_a_reg.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1))
                            ? '0 : wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1))
                            ? '0 : rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (push && !pop) begin
                fifo_count_reg <= fifo_count_reg + FIFO_CNT_W'(1);
            end else if (pop && !push) begin
                fifo_count_reg <= fifo_count_reg - FIFO_CNT_W'(1);
            end
        end
    end

    assign m_valid     = (fifo_count_reg != '0);
    assign m_pixel_out = fifo_pix_reg[rd_ptr_reg];
    assign m_frame_end = fifo_end_reg[rd_ptr_reg];

    // checks
    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_count_reg < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("result beat with the output queue full");

    a_flush_in_row_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg != '0) |-> (row_reg == '0))
        else $error("flush pending outside row zero");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (fifo_count_reg + FIFO_CNT_W'(valid_a_reg)) <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("beats in flight exceed queue depth");

endmodule
